// ===== hdl/scit_pkg.sv =====
package scit_pkg;

    localparam int CoordWidth  = 16;
    localparam int RadiusWidth = 15;
    localparam int DiffWidth   = CoordWidth + 1;
    localparam int SqWidth     = 2 * DiffWidth;
    localparam int SumWidth    = SqWidth + 1;
    localparam int QWidth      = SumWidth + 1;
    localparam int ProdWidth   = 2 * SumWidth;
    localparam int InDataWidth = 112;
    localparam int OutDataWidth = 8;

    // Flags carried from the stage where q0, q1 and h are known.
    typedef struct packed {
        logic a_zero;
        logic decided;
        logic decided_hit;
    } scit_flags_t;

endpackage

// ===== hdl/segment_circle_intersection_test_unit.sv =====
// Segment/circle boundary crossing test. One request per cycle is accepted
// and each produces one hit result after passing through the difference,
// square, classification, product and compare stages of the pipeline. A
// stall on the result side holds the whole pipeline without losing data.
module segment_circle_intersection_test_unit
    import scit_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // start_x, start_y, end_x, end_y, center_x, center_y, circle_radius, pad
    input  logic [InDataWidth-1:0] s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hit, pad
    output logic [OutDataWidth-1:0] m_tdata
);

    localparam int Depth = 5;

    logic [Depth-1:0] valid_reg;
    logic en;
    logic [SumWidth-1:0] a;
    logic signed [SumWidth:0] h;
    logic signed [QWidth-1:0] q0, q1;
    logic hit;

    assign en = m_tready || !valid_reg[Depth-1];
    assign s_tready = en;
    assign m_tvalid = valid_reg[Depth-1];
    assign m_tdata = {{(OutDataWidth-1){1'b0}}, hit};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[Depth-2:0], s_tvalid};
        end
    end

    scit_front u_front (
        .aclk(aclk), .en(en),
        .sx(s_tdata[15:0]), .sy(s_tdata[31:16]),
        .ex(s_tdata[47:32]), .ey(s_tdata[63:48]),
        .cx(s_tdata[79:64]), .cy(s_tdata[95:80]),
        .r(s_tdata[110:96]),
        .a(a), .h(h), .q0(q0), .q1(q1)
    );

    scit_back u_back (
        .aclk(aclk), .en(en), .a(a), .h(h), .q0(q0), .q1(q1), .hit(hit)
    );

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
    a_pad: assert property (@(posedge aclk) m_tdata[OutDataWidth-1:1] == '0)
        else $error("pad bits set");

endmodule

// ===== hdl/scit_front.sv =====
module scit_front
    import scit_pkg::*;
(
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [CoordWidth-1:0] sx,
    input  logic signed [CoordWidth-1:0] sy,
    input  logic signed [CoordWidth-1:0] ex,
    input  logic signed [CoordWidth-1:0] ey,
    input  logic signed [CoordWidth-1:0] cx,
    input  logic signed [CoordWidth-1:0] cy,
    input  logic [RadiusWidth-1:0]       r,
    output logic [SumWidth-1:0]          a,
    output logic signed [SumWidth:0]     h,
    output logic signed [QWidth-1:0]     q0,
    output logic signed [QWidth-1:0]     q1
);

    logic signed [DiffWidth-1:0] dx_reg, dy_reg, fx_reg, fy_reg, gx_reg, gy_reg;
    logic [RadiusWidth-1:0] r_reg;
    logic signed [SqWidth-1:0] dxx_reg, dyy_reg, fdx_reg, fdy_reg;
    logic signed [SqWidth-1:0] fxx_reg, fyy_reg, gxx_reg, gyy_reg;
    logic [2*RadiusWidth-1:0] rr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg <= DiffWidth'(ex) - DiffWidth'(sx);
            dy_reg <= DiffWidth'(ey) - DiffWidth'(sy);
            fx_reg <= DiffWidth'(sx) - DiffWidth'(cx);
            fy_reg <= DiffWidth'(sy) - DiffWidth'(cy);
            gx_reg <= DiffWidth'(ex) - DiffWidth'(cx);
            gy_reg <= DiffWidth'(ey) - DiffWidth'(cy);
            r_reg  <= r;
            dxx_reg <= dx_reg * dx_reg;
            dyy_reg <= dy_reg * dy_reg;
            fdx_reg <= fx_reg * dx_reg;
            fdy_reg <= fy_reg * dy_reg;
            fxx_reg <= fx_reg * fx_reg;
            fyy_reg <= fy_reg * fy_reg;
            gxx_reg <= gx_reg * gx_reg;
            gyy_reg <= gy_reg * gy_reg;
            rr_reg  <= r_reg * r_reg;
        end
    end

    assign a  = SumWidth'($unsigned(dxx_reg)) + SumWidth'($unsigned(dyy_reg));
    assign h  = (SumWidth+1)'(fdx_reg) + (SumWidth+1)'(fdy_reg);
    assign q0 = QWidth'($unsigned(fxx_reg)) + QWidth'($unsigned(fyy_reg))
              - QWidth'(rr_reg);
    assign q1 = QWidth'($unsigned(gxx_reg)) + QWidth'($unsigned(gyy_reg))
              - QWidth'(rr_reg);

endmodule

// ===== hdl/scit_back.sv =====
module scit_back
    import scit_pkg::*;
(
    input  logic                     aclk,
    input  logic                     en,
    input  logic [SumWidth-1:0]      a,
    input  logic signed [SumWidth:0] h,
    input  logic signed [QWidth-1:0] q0,
    input  logic signed [QWidth-1:0] q1,
    output logic                     hit
);

    scit_flags_t flags_reg, flags2_reg;
    logic [SumWidth-1:0] ah_reg, a_reg;
    logic [SumWidth-1:0] q0_reg;
    logic [ProdWidth-1:0] hh_reg, aq_reg;
    logic vertex_ok_reg, vertex2_reg;
    logic [SumWidth:0] neg_h;
    scit_flags_t flags_next;

    assign neg_h = $unsigned(-h);

    always_comb begin
        flags_next.a_zero = (a == '0);
        flags_next.decided = 1'b1;
        flags_next.decided_hit = 1'b0;
        if (q0 == '0 || q1 == '0) begin
            flags_next.decided_hit = 1'b1;
        end else if (q0[QWidth-1] != q1[QWidth-1]) begin
            flags_next.decided_hit = 1'b1;
        end else if (!q0[QWidth-1]) begin
            flags_next.decided = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flags_reg <= flags_next;
            // Vertex must fall in [0,1]: h <= 0 and -h <= a.
            vertex_ok_reg <= !(h > 0) && (neg_h <= (SumWidth+1)'(a));
            ah_reg <= neg_h[SumWidth-1:0];
            a_reg  <= a;
            q0_reg <= q0[SumWidth-1:0];
            flags2_reg  <= flags_reg;
            vertex2_reg <= vertex_ok_reg;
            hh_reg <= ah_reg * ah_reg;
            aq_reg <= a_reg * q0_reg;
            if (flags2_reg.a_zero) begin
                hit <= 1'b0;
            end else if (flags2_reg.decided) begin
                hit <= flags2_reg.decided_hit;
            end else begin
                hit <= vertex2_reg && (hh_reg >= aq_reg);
            end
        end
    end

endmodule

// ===== tb/segment_circle_intersection_test_unit_tb.sv =====
module segment_circle_intersection_test_unit_tb;
    import scit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        r;
    } segment_query_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [InDataWidth-1:0]  s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [OutDataWidth-1:0] m_tdata;

    bit   expected_hits[$];
    int   error_count = 0;
    int   idle_cycles = 0;
    bit   stall_enable = 1'b1;

    segment_circle_intersection_test_unit dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Exact decision: a root of q(t) = a t^2 + 2 h t + q0 in [0,1]; a zero-length segment never hits.
    function automatic bit boundary_crosses(segment_query_t q);
        longint dx, dy, fx, fy, gx, gy, a, h, q0, q1, rr;
        logic [127:0] hh, aq;
        dx = longint'(q.ex) - longint'(q.sx);
        dy = longint'(q.ey) - longint'(q.sy);
        fx = longint'(q.sx) - longint'(q.cx);
        fy = longint'(q.sy) - longint'(q.cy);
        gx = longint'(q.ex) - longint'(q.cx);
        gy = longint'(q.ey) - longint'(q.cy);
        rr = longint'({1'b0, q.r});
        a  = dx * dx + dy * dy;
        h  = fx * dx + fy * dy;
        q0 = fx * fx + fy * fy - rr * rr;
        q1 = gx * gx + gy * gy - rr * rr;
        if (a == 0) return 1'b0;
        if (q0 == 0 || q1 == 0) return 1'b1;
        if ((q0 < 0) != (q1 < 0)) return 1'b1;
        if (q0 < 0) return 1'b0;
        if (h > 0 || -h > a) return 1'b0;
        hh = 128'(-h) * 128'(-h);
        aq = 128'(a) * 128'(q0);
        return hh >= aq;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Valid stays high after a request is accepted; a gap or a drain drops it.
    task automatic send_query(segment_query_t q);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, q.r, q.cy, q.cx, q.ey, q.ex, q.sy, q.sx};
        expected_hits.push_back(boundary_crosses(q));
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_fields(int sx, int sy, int ex, int ey, int cx, int cy, int r);
        segment_query_t q;
        q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey; q.cx = cx; q.cy = cy; q.r = r;
        send_query(q);
    endtask

    // Result side: ready toggles with random stalls; each result is checked.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = stall_enable ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (expected_hits.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                bit want;
                want = expected_hits.pop_front();
                if (m_tdata[0] !== want)
                    report_mismatch($sformatf("hit %b expected %b", m_tdata[0], want));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic test_special_cases();
        send_fields(100, 100, 100, 100, 0, 0, 0);               // zero length
        send_fields(5, 0, 5, 0, 0, 0, 5);                       // point on circle
        send_fields(-1, 0, 1, 0, 0, 0, 10);                     // wholly inside
        send_fields(10, 0, 20, 0, 0, 0, 10);                    // start on circle
        send_fields(-20, 0, -10, 0, 0, 0, 10);                  // end on circle
        send_fields(-20, 10, 20, 10, 0, 0, 10);                 // tangent
        send_fields(-20, 11, 20, 11, 0, 0, 10);                 // near miss
        send_fields(0, 0, 30, 0, 0, 0, 10);                     // one end inside
        send_fields(-30, 5, 30, 5, 0, 0, 10);                   // crossing twice
        send_fields(20, 0, 40, 0, 0, 0, 10);                    // vertex outside
    endtask

    task automatic test_extremes();
        send_fields(-32768, -32768, 32767, 32767, 0, 0, 32767);
        send_fields(32767, -32768, -32768, 32767, 32767, 32767, 32767);
        send_fields(-32768, -32768, 32767, -32768, -32768, 32767, 32767);
        send_fields(-32768, 32767, 32767, 32767, 0, -32768, 0);
        send_fields(32767, 32767, -32768, -32768, -32768, -32768, 0);
        send_fields(-32768, 0, 32767, 0, 0, 0, 32767);
        send_fields(-1, -1, -1, -1, -1, -1, 32767);
        send_fields(0, -32768, 0, 32767, 32767, 0, 32767);
    endtask

    // Fully random queries mixed with circles near the segment, so that hits and misses both happen often.
    task automatic test_random_queries(int count);
        segment_query_t q;
        int span;
        repeat (count) begin
            q.sx = $urandom; q.sy = $urandom; q.ex = $urandom; q.ey = $urandom;
            q.cx = $urandom; q.cy = $urandom; q.r = $urandom;
            case ($urandom_range(0, 3))
                0: ;
                1: begin
                    span = 1 << $urandom_range(1, 14);
                    q.sx = q.cx + $signed($urandom_range(0, 2 * span)) - span;
                    q.sy = q.cy + $signed($urandom_range(0, 2 * span)) - span;
                    q.ex = q.cx + $signed($urandom_range(0, 2 * span)) - span;
                    q.ey = q.cy + $signed($urandom_range(0, 2 * span)) - span;
                    q.r  = $urandom_range(0, span);
                end
                2: begin
                    span = $urandom_range(1, 200);
                    q.sx = $signed($urandom_range(0, 400)) - 200;
                    q.sy = $signed($urandom_range(0, 400)) - 200;
                    q.ex = $signed($urandom_range(0, 400)) - 200;
                    q.ey = $signed($urandom_range(0, 400)) - 200;
                    q.cx = $signed($urandom_range(0, 40)) - 20;
                    q.cy = $signed($urandom_range(0, 40)) - 20;
                    q.r  = span;
                end
                default: begin
                    // Horizontal line at a distance close to the radius.
                    q.r  = $urandom_range(0, 16000);
                    q.cx = 0; q.cy = 0;
                    q.sy = q.r + $signed($urandom_range(0, 2)) - 1;
                    q.ey = q.sy;
                    q.sx = -$signed($urandom_range(0, 16000));
                    q.ex = $urandom_range(0, 16000);
                end
            endcase
            send_query(q);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_special_cases();
        test_extremes();
        test_random_queries(900);
        // Let the pipeline empty completely before the next burst.
        drain_results();
        stall_enable = 1'b0;
        test_random_queries(300);
        stall_enable = 1'b1;
        test_random_queries(630);
        drain_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_hits.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
